### rtl/core/aa_point_splat_additive_blend_defines.svh
// Assertion macros for the point splat blender.
// Used by the top level only; no dependencies.
`ifndef AA_POINT_SPLAT_ADDITIVE_BLEND_DEFINES_SVH
`define AA_POINT_SPLAT_ADDITIVE_BLEND_DEFINES_SVH
`ifndef SYNTH
`define PSAB_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("psab: check failed");
`define PSAB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("psab: check failed");
`else
`define PSAB_ASSERT_SAME(label, clk, rstn, ante, cons)
`define PSAB_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### rtl/core/psab_pkg.sv
// Shared types and codes for the point splat blender.
// No dependencies.
`timescale 1ns / 1ps
package psab_pkg;
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_SPLAT = 2'd1;
    localparam logic [1:0] CMD_PLOT  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef struct packed {
        logic load;
        logic fill_start;
        logic fill_init;
        logic fill_write;
        logic nb_clear;
        logic nb_next;
        logic mul;
        logic sqrt_start;
        logic weight;
        logic mem_read;
        logic mem_write;
        logic res_load;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       outside;
        logic       fill_done;
        logic       sqrt_busy;
        logic       nb_last;
    } status_t;
endpackage

### rtl/core/psab_isqrt.sv
// Iterative floor square root, one result bit per cycle.
// Standalone; used by psab_datapath.
`timescale 1ns / 1ps
module psab_isqrt #(
    parameter int RB = 9
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [2*RB-1:0] radicand,
    output logic            busy,
    output logic [RB-1:0]   root
);
    localparam int CW = $clog2(RB + 1);

    logic [2*RB-1:0] x_reg,    x_next;
    logic [RB+1:0]   rem_reg,  rem_next;
    logic [RB-1:0]   root_reg, root_next;
    logic [CW-1:0]   cnt_reg,  cnt_next;
    logic            busy_reg, busy_next;
    logic [RB+3:0]   rem_sh;
    logic [RB+3:0]   trial;
    logic            fits;

    always_comb begin
        rem_sh    = {rem_reg, x_reg[2*RB-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        fits      = (rem_sh >= trial);
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(RB);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            x_next    = {x_reg[2*RB-3:0], 2'b00};
            rem_next  = fits ? (RB+2)'(rem_sh - trial) : (RB+2)'(rem_sh);
            root_next = {root_reg[RB-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;
endmodule

### rtl/core/psab_datapath.sv
// Datapath: config registers, request registers, weight arithmetic, frame memory.
// Depends on psab_pkg and psab_isqrt.
`timescale 1ns / 1ps
module psab_datapath #(
    parameter int MAX_WIDTH     = 64,
    parameter int MAX_HEIGHT    = 64,
    parameter int FRACTION_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [psab_pkg::CFG_W-1:0] cfg_data,
    input  logic [1:0]                s_cmd,
    input  logic signed [15:0]        s_pos_x,
    input  logic signed [15:0]        s_pos_y,
    input  logic [7:0]                s_red,
    input  logic [7:0]                s_green,
    input  logic [7:0]                s_blue,
    input  logic [7:0]                s_alpha,
    input  psab_pkg::ctrl_t           ctrl,
    output psab_pkg::status_t         status,
    output logic [31:0]               m_pixel_word,
    output logic                      m_outside
);
    import psab_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int FB    = FRACTION_BITS;
    localparam int IW    = 16 - FB;
    localparam int RB    = FB + 1;
    localparam logic [FB:0] FRAC_ONE = (FB+1)'(1) << FB;

    logic [CFG_W-1:0] cfg_w_reg, cfg_h_reg;
    logic [WW-1:0]    used_w;
    logic [HW-1:0]    used_h;

    logic [1:0]  cmd_reg;
    logic [15:0] px_reg, py_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg;

    logic [AW-1:0] base_reg, addr_reg, area_reg;
    logic [AW-1:0] fill_addr_reg, fill_last_reg;
    logic [31:0]   fill_data_reg;
    logic [1:0]    nb_reg;
    logic [2*RB-1:0] prod_reg;
    logic [7:0]    weight_reg;
    logic [31:0]   rdata_reg;
    logic [31:0]   word_reg;
    logic          outside_reg;

    logic [31:0] mem [DEPTH];

    logic [IW-1:0] ix, iy;
    logic [FB-1:0] fx, fy;
    logic [FB:0]   wx, wy;
    logic          negative, out_splat, out_pixel, outside;
    logic [RB-1:0] root;
    logic          sqrt_busy;
    logic [RB+7:0] scaled;
    logic [31:0]   blended;

    function automatic logic [7:0] add_sat(input logic [7:0] dst, input logic [7:0] src,
                                           input logic [7:0] w);
        logic [15:0] p;
        logic [8:0]  s;
        begin
            p = src * w;
            s = {1'b0, dst} + {1'b0, p[15:8]};
            add_sat = s[8] ? 8'hFF : s[7:0];
        end
    endfunction

    // clamp the frame size to at least 2 and to what the store can hold
    always_comb begin
        if (32'(cfg_w_reg) < 32'd2) used_w = WW'(2);
        else if (32'(cfg_w_reg) > 32'(MAX_WIDTH)) used_w = WW'(MAX_WIDTH);
        else used_w = WW'(cfg_w_reg);
        if (32'(cfg_h_reg) < 32'd2) used_h = HW'(2);
        else if (32'(cfg_h_reg) > 32'(MAX_HEIGHT)) used_h = HW'(MAX_HEIGHT);
        else used_h = HW'(cfg_h_reg);
    end

    always_comb begin
        ix        = px_reg[15:FB];
        iy        = py_reg[15:FB];
        fx        = px_reg[FB-1:0];
        fy        = py_reg[FB-1:0];
        negative  = px_reg[15] | py_reg[15];
        out_splat = negative || (32'(ix) >= 32'(used_w) - 32'd1)
                             || (32'(iy) >= 32'(used_h) - 32'd1);
        out_pixel = negative || (32'(ix) >= 32'(used_w)) || (32'(iy) >= 32'(used_h));
        case (cmd_reg)
            CMD_CLEAR: outside = 1'b0;
            CMD_SPLAT: outside = out_splat;
            default:   outside = out_pixel;
        endcase
        wx = nb_reg[0] ? {1'b0, fx} : (FRAC_ONE - {1'b0, fx});
        wy = nb_reg[1] ? {1'b0, fy} : (FRAC_ONE - {1'b0, fy});
        scaled  = root * alpha_reg;
        blended = {8'h00,
                   add_sat(rdata_reg[23:16], blue_reg,  weight_reg),
                   add_sat(rdata_reg[15:8],  green_reg, weight_reg),
                   add_sat(rdata_reg[7:0],   red_reg,   weight_reg)};
    end

    psab_isqrt #(.RB(RB)) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.sqrt_start),
        .radicand (prod_reg),
        .busy     (sqrt_busy),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg <= CFG_RESET;
            cfg_h_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  cfg_w_reg <= cfg_data;
                REG_FRAME_HEIGHT: cfg_h_reg <= cfg_data;
                default:          cfg_w_reg <= cfg_w_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg   <= s_cmd;
            px_reg    <= s_pos_x;
            py_reg    <= s_pos_y;
            red_reg   <= s_red;
            green_reg <= s_green;
            blue_reg  <= s_blue;
            alpha_reg <= s_alpha;
        end
        base_reg <= AW'(32'(iy) * 32'(used_w) + 32'(ix));
        area_reg <= AW'(32'(used_w) * 32'(used_h) - 32'd1);

        if (ctrl.fill_start) begin
            fill_addr_reg <= '0;
            fill_last_reg <= ctrl.fill_init ? AW'(DEPTH - 1) : area_reg;
            fill_data_reg <= ctrl.fill_init ? 32'd0
                                            : {alpha_reg, blue_reg, green_reg, red_reg};
        end else if (ctrl.fill_write) begin
            fill_addr_reg <= fill_addr_reg + 1'b1;
        end

        if (ctrl.nb_clear) nb_reg <= 2'd0;
        else if (ctrl.nb_next) nb_reg <= nb_reg + 2'd1;

        if (ctrl.mul) begin
            prod_reg <= (2*RB)'(wx * wy);
            addr_reg <= AW'(32'(base_reg) + 32'(nb_reg[0])
                            + (nb_reg[1] ? 32'(used_w) : 32'd0));
        end

        if (ctrl.weight) begin
            weight_reg <= (cmd_reg == CMD_SPLAT) ? scaled[FB +: 8] : alpha_reg;
        end

        if (ctrl.res_load) begin
            word_reg    <= (cmd_reg == CMD_READ && !outside) ? rdata_reg : 32'd0;
            outside_reg <= outside;
        end
    end

    // single write port shared by the fill sweep and the blend write-back
    always_ff @(posedge aclk) begin
        if (ctrl.fill_write) begin
            mem[fill_addr_reg] <= fill_data_reg;
        end else if (ctrl.mem_write) begin
            mem[addr_reg] <= blended;
        end
        if (ctrl.mem_read) begin
            rdata_reg <= mem[addr_reg];
        end
    end

    always_comb begin
        status.cmd       = cmd_reg;
        status.outside   = outside;
        status.fill_done = (fill_addr_reg == fill_last_reg);
        status.sqrt_busy = sqrt_busy;
        status.nb_last   = (nb_reg == 2'd3);
    end

    assign m_pixel_word = word_reg;
    assign m_outside    = outside_reg;
endmodule

### rtl/core/psab_controller.sv
// Sequencer for clear, splat, plot and read requests.
// Depends on psab_pkg.
`timescale 1ns / 1ps
module psab_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  psab_pkg::status_t status,
    output psab_pkg::ctrl_t   ctrl
);
    import psab_pkg::*;

    localparam logic [3:0] S_BOOT   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_IDLE   = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_FILL   = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_SQRT   = 4'd6;
    localparam logic [3:0] S_WAIT   = 4'd7;
    localparam logic [3:0] S_WEIGHT = 4'd8;
    localparam logic [3:0] S_READ   = 4'd9;
    localparam logic [3:0] S_WRITE  = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        ctrl         = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        case (state_reg)
            S_BOOT: begin
                ctrl.fill_start = 1'b1;
                ctrl.fill_init  = 1'b1;
                state_next      = S_INIT;
            end
            S_INIT: begin
                ctrl.fill_write = 1'b1;
                if (status.fill_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready   = 1'b1;
                ctrl.load = s_valid;
                if (s_valid) state_next = S_CHECK;
            end
            S_CHECK: begin
                if (status.outside) begin
                    state_next = S_DONE;
                end else if (status.cmd == CMD_CLEAR) begin
                    ctrl.fill_start = 1'b1;
                    state_next      = S_FILL;
                end else begin
                    ctrl.nb_clear = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_FILL: begin
                ctrl.fill_write = 1'b1;
                if (status.fill_done) state_next = S_DONE;
            end
            S_MUL: begin
                ctrl.mul = 1'b1;
                case (status.cmd)
                    CMD_SPLAT: state_next = S_SQRT;
                    CMD_PLOT:  state_next = S_WEIGHT;
                    default:   state_next = S_READ;
                endcase
            end
            S_SQRT: begin
                ctrl.sqrt_start = 1'b1;
                state_next      = S_WAIT;
            end
            S_WAIT: begin
                if (!status.sqrt_busy) state_next = S_WEIGHT;
            end
            S_WEIGHT: begin
                ctrl.weight = 1'b1;
                state_next  = S_READ;
            end
            S_READ: begin
                ctrl.mem_read = 1'b1;
                state_next    = (status.cmd == CMD_READ) ? S_DONE : S_WRITE;
            end
            S_WRITE: begin
                ctrl.mem_write = 1'b1;
                if (status.cmd == CMD_SPLAT && !status.nb_last) begin
                    ctrl.nb_next = 1'b1;
                    state_next   = S_MUL;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    ctrl.res_load = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_BOOT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
endmodule

### rtl/core/aa_point_splat_additive_blend.sv
// Plot and splat requests run a read-modify-write of the single-port frame memory and a
// read only reads it; a splat also runs the bit-serial square root for each of its four
// neighbour pixels, a clear sweeps the frame area and a rejected position goes to the result.
// One request at a time: s_ready rises with m_valid, and
// a waiting result lets one more request in, which then holds until the result leaves.
// Reset (sync, active low) sweeps the frame memory to zero.
`timescale 1ns / 1ps
`include "aa_point_splat_additive_blend_defines.svh"
module aa_point_splat_additive_blend #(
    parameter int MAX_WIDTH     = 64,
    parameter int MAX_HEIGHT    = 64,
    parameter int FRACTION_BITS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [psab_pkg::CFG_W-1:0] cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_cmd,
    input  logic signed [15:0]         s_pos_x,
    input  logic signed [15:0]         s_pos_y,
    input  logic [7:0]                 s_red,
    input  logic [7:0]                 s_green,
    input  logic [7:0]                 s_blue,
    input  logic [7:0]                 s_alpha,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [31:0]                m_pixel_word,
    output logic                       m_outside
);
    import psab_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    psab_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    psab_datapath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_cmd        (s_cmd),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .s_alpha      (s_alpha),
        .ctrl         (ctrl),
        .status       (status),
        .m_pixel_word (m_pixel_word),
        .m_outside    (m_outside)
    );

    `PSAB_ASSERT_SAME(a_one_writer, aclk, aresetn, ctrl.fill_write, !ctrl.mem_write)
    `PSAB_ASSERT_NEXT(a_res_valid, aclk, aresetn, ctrl.res_load, m_valid)
    `PSAB_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `PSAB_ASSERT_NEXT(a_sqrt_runs, aclk, aresetn, ctrl.sqrt_start, status.sqrt_busy)
endmodule
